[hdl/swlm_pkg.sv]
// ----------------------------------------------------------------------------
// swlm_pkg
// shared types, constants and command/status structs of the latency matcher
// ----------------------------------------------------------------------------
package swlm_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int TID_W         = 22;
	localparam int TIME_W        = 48;
	localparam int CPU_W         = 8;
	localparam int CFG_ADDR_W    = 4;
	localparam int CFG_DATA_W    = 64;

	typedef enum logic [CFG_ADDR_W-4:0] {
		REG_WAIT_THRESHOLD = 1'b0
	} reg_index_t;

	typedef enum logic {
		OP_SWITCH = 1'b0,
		OP_WAKEUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REPORT_PASS      = 2'd0,
		REPORT_LONG_WAIT = 2'd1,
		REPORT_FULL      = 2'd2
	} report_kind_t;

	typedef struct packed {
		op_t                 operation;
		logic [TID_W-1:0]    task_id;
		logic [TIME_W-1:0]   timestamp;
		logic [CPU_W-1:0]    cpu;
	} in_item_t;

	typedef struct packed {
		report_kind_t        report_kind;
		logic [TID_W-1:0]    task_id_res;
		logic [TIME_W-1:0]   wait_time;
		logic [TIME_W-1:0]   sleep_time;
		logic [CPU_W-1:0]    sleep_cpu;
		logic [TIME_W-1:0]   event_time;
		logic [CPU_W-1:0]    event_cpu;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DECIDE,
		ST_READ,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic         capture;
		logic         match;
		logic         write_entry;
		logic         free_entry;
		logic         read_entry;
		logic         diff;
		logic         set_kind;
		report_kind_t kind;
		logic         load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic thr_zero;
		logic is_wakeup;
		logic hit_any;
		logic free_any;
		logic long_wait;
		logic res_free;
	} dp_status_t;

endpackage

[hdl/swlm_ctrl.sv]
// ----------------------------------------------------------------------------
// swlm_ctrl
// sequencer: steps one request through match, decide, read, check and emit
// ----------------------------------------------------------------------------
module swlm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swlm_pkg::dp_status_t status,
	output swlm_pkg::dp_cmd_t    cmd
);

	swlm_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			swlm_pkg::ST_IDLE: begin
				if (in_valid) state_nx = swlm_pkg::ST_MATCH;
			end
			swlm_pkg::ST_MATCH: begin
				state_nx = status.thr_zero ? swlm_pkg::ST_EMIT : swlm_pkg::ST_DECIDE;
			end
			swlm_pkg::ST_DECIDE: begin
				if (status.is_wakeup) begin
					state_nx = status.hit_any ? swlm_pkg::ST_READ : swlm_pkg::ST_IDLE;
				end else begin
					state_nx = (status.hit_any || status.free_any) ?
						swlm_pkg::ST_IDLE : swlm_pkg::ST_EMIT;
				end
			end
			swlm_pkg::ST_READ: begin
				state_nx = swlm_pkg::ST_CHECK;
			end
			swlm_pkg::ST_CHECK: begin
				state_nx = status.long_wait ? swlm_pkg::ST_EMIT : swlm_pkg::ST_IDLE;
			end
			swlm_pkg::ST_EMIT: begin
				if (status.res_free) state_nx = swlm_pkg::ST_IDLE;
			end
			default: state_nx = swlm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.kind = swlm_pkg::REPORT_PASS;
		in_ready = 1'b0;
		unique case (state_q)
			swlm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			swlm_pkg::ST_MATCH: begin
				cmd.match    = 1'b1;
				cmd.set_kind = status.thr_zero;
				cmd.kind     = swlm_pkg::REPORT_PASS;
			end
			swlm_pkg::ST_DECIDE: begin
				if (status.is_wakeup) begin
					cmd.free_entry = status.hit_any;
					cmd.read_entry = status.hit_any;
				end else if (status.hit_any || status.free_any) begin
					cmd.write_entry = 1'b1;
				end else begin
					cmd.set_kind = 1'b1;
					cmd.kind     = swlm_pkg::REPORT_FULL;
				end
			end
			swlm_pkg::ST_READ: begin
				cmd.diff = 1'b1;
			end
			swlm_pkg::ST_CHECK: begin
				cmd.set_kind = status.long_wait;
				cmd.kind     = swlm_pkg::REPORT_LONG_WAIT;
			end
			swlm_pkg::ST_EMIT: begin
				cmd.load_result = status.res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hdl/swlm_dp.sv]
// ----------------------------------------------------------------------------
// swlm_dp
// datapath: tag match over the entry registers, time/cpu memory, threshold
// register, wait arithmetic and the result register
// ----------------------------------------------------------------------------
module swlm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swlm_pkg::in_item_t                   in_data,
	input  swlm_pkg::dp_cmd_t                    cmd,
	output swlm_pkg::dp_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [swlm_pkg::TIME_W-1:0]          cfg_wdata,
	output logic [swlm_pkg::TIME_W-1:0]          threshold,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output swlm_pkg::out_item_t                  out_data
);

	localparam int N  = swlm_pkg::TABLE_ENTRIES;
	localparam int IW = swlm_pkg::IDX_W;
	localparam int TW = swlm_pkg::TIME_W;
	localparam int CW = swlm_pkg::CPU_W;

	logic [TW-1:0]                 thr_q;
	swlm_pkg::in_item_t            item_q;
	logic [N-1:0]                  valid_q;
	logic [swlm_pkg::TID_W-1:0]    tag_q [N];
	logic [N-1:0]                  hit_s1, free_s1;
	logic [TW+CW-1:0]              mem [N];
	logic [TW+CW-1:0]              rdata_q;
	logic [IW-1:0]                 ent_idx_q;
	logic [TW:0]                   diff_q;
	swlm_pkg::report_kind_t        kind_q;
	logic                          res_valid_q;
	swlm_pkg::out_item_t           res_q;

	logic [IW-1:0]                 hit_idx, free_idx, slot_idx;
	logic [TW:0]                   sub;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end
	assign threshold = thr_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_data;
	end

	// tag compare against every entry, registered
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			for (int i = 0; i < N; i++) begin
				hit_s1[i]  <= valid_q[i] && (tag_q[i] == item_q.task_id);
				free_s1[i] <= !valid_q[i];
			end
		end
	end

	// at most one entry holds a task, so the hit index is an or of indexes
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_s1[i]) hit_idx = hit_idx | IW'(i);
		end
	end

	// lowest free entry
	always_comb begin
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (free_s1[i]) free_idx = IW'(i);
		end
	end

	assign slot_idx = (|hit_s1) ? hit_idx : free_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.write_entry) begin
			valid_q[slot_idx] <= 1'b1;
		end else if (cmd.free_entry) begin
			valid_q[hit_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_entry) tag_q[slot_idx] <= item_q.task_id;
	end

	// sleep time and cpu store
	always_ff @(posedge clk) begin
		if (cmd.write_entry) mem[slot_idx] <= {item_q.timestamp, item_q.cpu};
		if (cmd.read_entry)  rdata_q <= mem[hit_idx];
	end

	// wake minus sleep, borrow kept in the top bit
	assign sub = {1'b0, item_q.timestamp} - {1'b0, rdata_q[TW+CW-1:CW]};

	always_ff @(posedge clk) begin
		if (cmd.diff) diff_q <= sub;
		if (cmd.set_kind) kind_q <= cmd.kind;
		if (cmd.read_entry) ent_idx_q <= hit_idx;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_q.report_kind <= kind_q;
			res_q.task_id_res <= item_q.task_id;
			res_q.event_time  <= item_q.timestamp;
			res_q.event_cpu   <= item_q.cpu;
			if (kind_q == swlm_pkg::REPORT_LONG_WAIT) begin
				res_q.wait_time  <= diff_q[TW-1:0];
				res_q.sleep_time <= rdata_q[TW+CW-1:CW];
				res_q.sleep_cpu  <= rdata_q[CW-1:0];
			end else begin
				res_q.wait_time  <= '0;
				res_q.sleep_time <= '0;
				res_q.sleep_cpu  <= '0;
			end
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// nonzero threshold plus no borrow covers wake later than sleep
	assign status.thr_zero  = (thr_q == '0);
	assign status.is_wakeup = (item_q.operation == swlm_pkg::OP_WAKEUP);
	assign status.hit_any   = |hit_s1;
	assign status.free_any  = |free_s1;
	assign status.long_wait = !diff_q[TW] && (diff_q[TW-1:0] > thr_q) && valid_q[ent_idx_q] == 1'b0;
	assign status.res_free  = !res_valid_q || out_ready;

endmodule

[hdl/sleep_wakeup_latency_matcher.sv]
// ----------------------------------------------------------------------------
// sleep_wakeup_latency_matcher
// pairs task switch-out and wakeup events and reports sleeps longer than a
// programmable threshold
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake              payload
//  in_*         request in  in_valid / in_ready   in_data  (swlm_pkg::in_item_t)
//  out_*        result out  out_valid / out_ready out_data (swlm_pkg::out_item_t)
//  p*           apb slave   psel, penable, pready paddr, pwdata, prdata
//
//  one request at a time: a pass-through runs match and emit, a stored switch-out
//  or a wakeup that misses runs match and decide, a switch-out dropped on a full
//  table match, decide and emit, and a wakeup that finds its entry match, decide,
//  read and check, then emit if it reports; the steps are the registered tag match,
//  the time/cpu memory read and the 48-bit subtract and compare. a request is taken
//  while an earlier result still waits in the output register; a stalled output
//  only holds a new request at its emit step.
//  reset clears the threshold, all entry valid bits and the output valid.
//
module sleep_wakeup_latency_matcher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  swlm_pkg::in_item_t                   in_data,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output swlm_pkg::out_item_t                  out_data,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [swlm_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [swlm_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [swlm_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	swlm_pkg::dp_cmd_t               cmd;
	swlm_pkg::dp_status_t            status;
	logic                            cfg_we;
	logic                            thr_sel;
	logic [swlm_pkg::TIME_W-1:0]     threshold;

	// registers sit on 8-byte words, the low three address bits are ignored
	assign pready  = 1'b1;
	assign thr_sel = (paddr[swlm_pkg::CFG_ADDR_W-1:3] == swlm_pkg::REG_WAIT_THRESHOLD);
	assign cfg_we  = psel && penable && pwrite && thr_sel;
	assign prdata  = thr_sel ?
		{{(swlm_pkg::CFG_DATA_W - swlm_pkg::TIME_W){1'b0}}, threshold} : '0;

	// sequencer
	swlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// entry table, arithmetic and result register
	swlm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[swlm_pkg::TIME_W-1:0]),
		.threshold (threshold),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[bench/sleep_wakeup_latency_matcher_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sleep_wakeup_latency_matcher_tb
// drives scheduler switch-out and wakeup requests into the latency matcher,
// predicts each report from a behavioral copy of the sleep table and checks
// every result field by field, under random idling and long output stalls
// ----------------------------------------------------------------------------
module sleep_wakeup_latency_matcher_tb;

	localparam int TABLE_ENTRIES = swlm_pkg::TABLE_ENTRIES;
	localparam int TID_W         = swlm_pkg::TID_W;
	localparam int TIME_W        = swlm_pkg::TIME_W;
	localparam int CPU_W         = swlm_pkg::CPU_W;
	localparam int CFG_ADDR_W    = swlm_pkg::CFG_ADDR_W;
	localparam int CFG_DATA_W    = swlm_pkg::CFG_DATA_W;

	localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer before giving up
	localparam int SETTLE_CYCLES = 16;    // lets a request with no report finish its pass
	localparam int HOLD_OFF_LEN  = 200;   // long receiver stall in the pressure test

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	// request and result channels
	logic                in_valid  = 1'b0;
	logic                in_ready;
	swlm_pkg::in_item_t  in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	swlm_pkg::out_item_t out_data;

	// configuration port
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	sleep_wakeup_latency_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predicted copy of the threshold register and the sleep table
	logic [TIME_W-1:0] model_threshold = '0;
	logic              sleep_valid [TABLE_ENTRIES];
	logic [TID_W-1:0]  sleep_task  [TABLE_ENTRIES];
	logic [TIME_W-1:0] sleep_stamp [TABLE_ENTRIES];
	logic [CPU_W-1:0]  sleep_cpu_tab [TABLE_ENTRIES];

	// reports still owed by the block, oldest first
	swlm_pkg::out_item_t pending_reports [$];

	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// idling knobs, the rates in percent of cycles and the hold-off in cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_off_left  = 0;

	// random traffic state
	logic [TID_W-1:0]  task_pool_base = '0;
	logic [TIME_W-1:0] now_ts         = '0;

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sleep_valid[i]   = 1'b0;
			sleep_task[i]    = '0;
			sleep_stamp[i]   = '0;
			sleep_cpu_tab[i] = '0;
		end
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// index of the valid entry holding this task, -1 when none
	function automatic int lookup_task(logic [TID_W-1:0] tid);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (sleep_valid[i] && sleep_task[i] == tid)
				return i;
		return -1;
	endfunction

	// works out the report (if any) of one accepted request and updates the table
	function automatic void predict_wait_report(swlm_pkg::in_item_t req);
		swlm_pkg::out_item_t rep;
		int                  slot;
		logic [TIME_W-1:0]   slept;
		rep             = '0;
		rep.task_id_res = req.task_id;
		rep.event_time  = req.timestamp;
		rep.event_cpu   = req.cpu;
		// matching off: every request passes straight through
		if (model_threshold == '0) begin
			rep.report_kind = swlm_pkg::REPORT_PASS;
			pending_reports.push_back(rep);
			return;
		end
		slot = lookup_task(req.task_id);
		if (req.operation == swlm_pkg::OP_SWITCH) begin
			// new task takes the lowest free entry
			if (slot < 0)
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (!sleep_valid[i]) begin
						slot = i;
						break;
					end
			if (slot < 0) begin
				rep.report_kind = swlm_pkg::REPORT_FULL;
				pending_reports.push_back(rep);
				return;
			end
			sleep_valid[slot]   = 1'b1;
			sleep_task[slot]    = req.task_id;
			sleep_stamp[slot]   = req.timestamp;
			sleep_cpu_tab[slot] = req.cpu;
			return;
		end
		// wakeup of an unknown task leaves no trace
		if (slot < 0)
			return;
		sleep_valid[slot] = 1'b0;
		slept = req.timestamp - sleep_stamp[slot];
		if (req.timestamp > sleep_stamp[slot] && slept > model_threshold) begin
			rep.report_kind = swlm_pkg::REPORT_LONG_WAIT;
			rep.wait_time   = slept;
			rep.sleep_time  = sleep_stamp[slot];
			rep.sleep_cpu   = sleep_cpu_tab[slot];
			pending_reports.push_back(rep);
		end
	endfunction

	task automatic check_report(swlm_pkg::out_item_t got);
		swlm_pkg::out_item_t want;
		if (pending_reports.size() == 0) begin
			report_mismatch("result with none expected, task", got.task_id_res, 0);
			return;
		end
		want = pending_reports.pop_front();
		if (got.report_kind !== want.report_kind)
			report_mismatch("report_kind", got.report_kind, want.report_kind);
		if (got.task_id_res !== want.task_id_res)
			report_mismatch("task_id_res", got.task_id_res, want.task_id_res);
		if (got.wait_time !== want.wait_time)
			report_mismatch("wait_time", got.wait_time, want.wait_time);
		if (got.sleep_time !== want.sleep_time)
			report_mismatch("sleep_time", got.sleep_time, want.sleep_time);
		if (got.sleep_cpu !== want.sleep_cpu)
			report_mismatch("sleep_cpu", got.sleep_cpu, want.sleep_cpu);
		if (got.event_time !== want.event_time)
			report_mismatch("event_time", got.event_time, want.event_time);
		if (got.event_cpu !== want.event_cpu)
			report_mismatch("event_cpu", got.event_cpu, want.event_cpu);
	endtask

	// accepted requests feed the predictor, accepted results go to the checker
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_wait_report(in_data);
		if (arst_n && out_valid && out_ready)
			check_report(out_data);
	end

	// watchdog: any transfer on either channel or the config port restarts it
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("sleep_wakeup_latency_matcher_tb: FAIL");
			$finish;
		end
	end

	// receiver: a long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_ready <= 1'b0;
			hold_off_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic swlm_pkg::in_item_t sched_event(swlm_pkg::op_t op,
			logic [TID_W-1:0] tid, logic [TIME_W-1:0] ts, logic [CPU_W-1:0] cpu);
		swlm_pkg::in_item_t ev;
		ev.operation = op;
		ev.task_id   = tid;
		ev.timestamp = ts;
		ev.cpu       = cpu;
		return ev;
	endfunction

	// mostly well-formed traffic over a small pool of tasks on a running clock,
	// with some fully random noise requests; wide_times gives random 48-bit times
	function automatic swlm_pkg::in_item_t make_sched_event(int unsigned pool_size,
			int unsigned noise_pct, bit wide_times);
		swlm_pkg::in_item_t ev;
		ev.cpu = CPU_W'($urandom_range(255));
		if ($urandom_range(99) < noise_pct) begin
			ev.operation = $urandom_range(1) ? swlm_pkg::OP_WAKEUP : swlm_pkg::OP_SWITCH;
			ev.task_id   = TID_W'($urandom);
			ev.timestamp = TIME_W'({$urandom, $urandom});
		end else begin
			ev.operation = ($urandom_range(99) < 52) ? swlm_pkg::OP_SWITCH :
				swlm_pkg::OP_WAKEUP;
			ev.task_id   = task_pool_base + TID_W'($urandom_range(pool_size - 1));
			now_ts       = now_ts + TIME_W'($urandom_range(64));
			ev.timestamp = wide_times ? TIME_W'({$urandom, $urandom}) : now_ts;
		end
		return ev;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so a back-to-back request needs no second assignment
	task automatic send_request(swlm_pkg::in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering requests and wait until every owed report has come,
	// then let any request with no report finish its pass
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write of the threshold while the block is idle, then read it back
	task automatic write_threshold(logic [TIME_W-1:0] value);
		wait_for_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {swlm_pkg::REG_WAIT_THRESHOLD, 3'b000};
		pwdata  <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		model_threshold = value;
		@(negedge clk);
		// read-back transfer
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[TIME_W-1:0] !== value)
			report_mismatch("wait_threshold read-back", prdata[TIME_W-1:0], value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// threshold zero after reset: every request comes back as a pass-through,
	// field extremes on both operations
	task automatic test_pass_through();
		send_request(sched_event(swlm_pkg::OP_SWITCH, '0, '0, '0));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, '1, '1, '1));
		send_request(sched_event(swlm_pkg::OP_SWITCH, '1, '1, 8'h5a));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, '0, '0, '0));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h155555, 48'haaaa_5555_aaaa,
			8'ha5));
		wait_for_idle();
	endtask

	// each switch/wakeup case with the threshold at a small value and at max
	task automatic test_wait_matching();
		write_threshold(48'd100);
		// just over the threshold reports
		send_request(sched_event(swlm_pkg::OP_SWITCH, 22'h000011, 48'd1000, 8'd5));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h000011, 48'd1101, 8'd6));
		// exactly the threshold does not, and the entry is freed anyway
		send_request(sched_event(swlm_pkg::OP_SWITCH, 22'h000011, 48'd1000, 8'd7));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h000011, 48'd1100, 8'd8));
		// second wakeup finds nothing
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h000011, 48'd9000, 8'd9));
		// overwrite, then wake before the stored time
		send_request(sched_event(swlm_pkg::OP_SWITCH, 22'h3ffffe, 48'd5000, 8'd1));
		send_request(sched_event(swlm_pkg::OP_SWITCH, 22'h3ffffe, 48'd6000, 8'hff));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h3ffffe, 48'd5500, 8'd2));
		// wake time equal to sleep time
		send_request(sched_event(swlm_pkg::OP_SWITCH, 22'h200000, 48'd500, 8'd3));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h200000, 48'd500, 8'd3));
		// sleep at max time, wake at zero
		send_request(sched_event(swlm_pkg::OP_SWITCH, '1, '1, 8'h80));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, '1, '0, 8'h01));
		// longest possible wait
		send_request(sched_event(swlm_pkg::OP_SWITCH, '0, '0, '1));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, '0, '1, '0));
		// at max threshold nothing can be long enough
		write_threshold('1);
		send_request(sched_event(swlm_pkg::OP_SWITCH, 22'h0abcde, '0, 8'h11));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, 22'h0abcde, '1, 8'h22));
		wait_for_idle();
	endtask

	// fill all entries, hit the full case, overwrite, free one and refill it,
	// then wake everything so the table ends empty
	task automatic test_table_full();
		logic [TID_W-1:0]  base_tid;
		logic [TIME_W-1:0] base_ts;
		base_tid = 22'h2a0000;
		base_ts  = 48'h0000_1000_0000;
		write_threshold(48'd1);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			send_request(sched_event(swlm_pkg::OP_SWITCH, base_tid + TID_W'(i), base_ts,
				CPU_W'(i)));
		send_request(sched_event(swlm_pkg::OP_SWITCH, base_tid + TID_W'(TABLE_ENTRIES),
			base_ts, 8'hee));
		send_request(sched_event(swlm_pkg::OP_SWITCH, base_tid + 22'd3, base_ts - 48'd5,
			8'hcc));
		send_request(sched_event(swlm_pkg::OP_WAKEUP, base_tid + 22'd10, base_ts + 48'd2,
			8'hdd));
		send_request(sched_event(swlm_pkg::OP_SWITCH, base_tid + TID_W'(TABLE_ENTRIES),
			base_ts, 8'hee));
		for (int i = 0; i <= TABLE_ENTRIES; i++)
			send_request(sched_event(swlm_pkg::OP_WAKEUP, base_tid + TID_W'(i),
				base_ts + 48'd1, 8'h44));
		wait_for_idle();
	endtask

	// receiver holds off while the sender keeps offering, so the block
	// fills and stalls its input; then the sender waits for every report
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_threshold('0);
		task_pool_base = TID_W'($urandom);
		now_ts         = TIME_W'({$urandom, $urandom});
		hold_off_left  = HOLD_OFF_LEN;
		repeat (24) send_request(make_sched_event(16, 10, 1'b0));
		wait_for_idle();
		repeat (10) send_request(make_sched_event(16, 10, 1'b0));
		wait_for_idle();
	endtask

	// random traffic under each idling mix, then a phase of wide random times
	task automatic test_random_traffic();
		int send_mix [4];
		int recv_mix [4];
		int pool_mix [4];
		send_mix = '{0, 58, 0, 35};
		recv_mix = '{0, 0, 58, 35};
		pool_mix = '{12, 24, 40, 80};
		for (int p = 0; p < 4; p++) begin
			write_threshold(TIME_W'($urandom_range(600, 1)));
			send_idle_pct  = send_mix[p];
			recv_stall_pct = recv_mix[p];
			task_pool_base = TID_W'($urandom);
			now_ts         = TIME_W'({$urandom, $urandom});
			repeat (105) send_request(make_sched_event(pool_mix[p], 10, 1'b0));
		end
		// large random threshold against random 48-bit times
		write_threshold((TIME_W'({$urandom, $urandom}) >> $urandom_range(47)) | 48'd1);
		repeat (40) send_request(make_sched_event(16, 10, 1'b1));
		wait_for_idle();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_pass_through();
		test_wait_matching();
		test_table_full();
		test_backpressure();
		test_random_traffic();

		// final drain, then a settling wait to catch any stray result
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_for_idle();
		if (mismatch_count == 0)
			$display("sleep_wakeup_latency_matcher_tb: PASS");
		else
			$display("sleep_wakeup_latency_matcher_tb: FAIL");
		$finish;
	end

endmodule

[sim.f]
hdl/swlm_pkg.sv
hdl/swlm_ctrl.sv
hdl/swlm_dp.sv
hdl/sleep_wakeup_latency_matcher.sv
bench/sleep_wakeup_latency_matcher_tb.sv
